// File: src/rbfta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rbfta_pkg;

    typedef struct packed {
        logic               clear_sums;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [31:0] centre_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] sum_force_x;
        logic signed [31:0] sum_force_y;
        logic signed [31:0] sum_force_z;
        logic signed [31:0] sum_torque_x;
        logic signed [31:0] sum_torque_y;
        logic signed [31:0] sum_torque_z;
    } out_word_t;

    // Operand width of the serial multiplier and width of its product.
    localparam int MUL_W = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [50:0] SAT_MAX = 51'sd2147483647;
    localparam logic signed [50:0] SAT_MIN = -51'sd2147483648;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                   input logic signed [49:0] delta);
        logic signed [50:0] t;
        t = 51'(acc) + 51'(delta);
        if (t > SAT_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (t < SAT_MIN) begin
            return -32'sh8000_0000;
        end
        return t[31:0];
    endfunction

endpackage
`default_nettype wire

// File: src/rigid_body_force_torque_accumulator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Accumulates the linear force and torque that world-space forces exert on a rigid
// body; every accepted word returns both saturated running sums. A word with a zero
// force or a zero offset goes straight to the result state, and its result is loaded
// once the output register is free. Any other word is worked through in order: two
// unit-vector passes, each of up to 30 normalizing shifts, three serial squares, a
// 32-step square root and three divisions, followed by twelve products on the
// one-bit-a-cycle multiplier. No new word is taken until the result is loaded, and
// a stalled result holds the block until it is taken.
module rigid_body_force_torque_accumulator_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire rbfta_pkg::in_word_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output rbfta_pkg::out_word_t      out_data
);

    localparam int MW = rbfta_pkg::MUL_W;
    localparam int PW = rbfta_pkg::PROD_W;

    typedef enum logic [2:0] {T_IDLE, T_UD, T_UF, T_DOT, T_SCL, T_TRQ, T_FIN} tstate_t;

    tstate_t            state_reg;
    logic               wait_reg;
    logic [2:0]         idx_reg;
    logic signed [31:0] f_reg [3];
    logic signed [32:0] d_reg [3];
    logic signed [31:0] u_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [65:0] acc_reg;
    logic signed [33:0] s_reg;
    logic signed [PW-1:0] a_reg;
    logic signed [31:0] fsum_reg [3];
    logic signed [31:0] tsum_reg [3];
    rbfta_pkg::out_word_t out_reg;
    logic               out_valid_reg;

    logic signed [31:0] f_in [3];
    logic signed [32:0] d_in [3];
    logic               fzero;
    logic               dzero;
    logic               accept;
    logic               load_out;

    logic               unit_start;
    logic               unit_done;
    logic signed [32:0] unit_vec [3];
    logic signed [31:0] unit_u [3];

    logic               mul_start;
    logic               mul_done;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] mul_prod;

    logic signed [65:0] acc_next;
    logic signed [65:0] s_wide;
    logic signed [PW-1:0] scl_round;
    logic signed [PW:0]   trq_diff;
    logic signed [PW:0]   trq_round;
    logic signed [31:0] fsum_sel;
    logic signed [31:0] tsum_sel;
    logic signed [31:0] fsum_new;
    logic signed [31:0] tsum_new;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != T_IDLE);

    always_comb
    begin
        f_in[0] = in_data.force_x;
        f_in[1] = in_data.force_y;
        f_in[2] = in_data.force_z;
        d_in[0] = 33'(in_data.point_x) - 33'(in_data.centre_x);
        d_in[1] = 33'(in_data.point_y) - 33'(in_data.centre_y);
        d_in[2] = 33'(in_data.point_z) - 33'(in_data.centre_z);
        fzero = (f_in[0] == 0) && (f_in[1] == 0) && (f_in[2] == 0);
        dzero = (d_in[0] == 0) && (d_in[1] == 0) && (d_in[2] == 0);
    end

    assign unit_start = ((state_reg == T_UD) || (state_reg == T_UF)) && !wait_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unit_vec[i] = (state_reg == T_UD) ? d_reg[i] : 33'(f_reg[i]);
        end
    end

    rbfta_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .vec   (unit_vec),
        .done  (unit_done),
        .u     (unit_u)
    );

    assign mul_start = ((state_reg == T_DOT) || (state_reg == T_SCL) ||
                        (state_reg == T_TRQ)) && !wait_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            T_DOT:
            begin
                case (idx_reg)
                    3'd0:    begin mul_a = MW'(f_reg[0]); mul_b = MW'(u_reg[0]); end
                    3'd1:    begin mul_a = MW'(f_reg[1]); mul_b = MW'(u_reg[1]); end
                    default: begin mul_a = MW'(f_reg[2]); mul_b = MW'(u_reg[2]); end
                endcase
            end
            T_SCL:
            begin
                mul_a = MW'(s_reg);
                case (idx_reg)
                    3'd0:    mul_b = MW'(v_reg[0]);
                    3'd1:    mul_b = MW'(v_reg[1]);
                    default: mul_b = MW'(v_reg[2]);
                endcase
            end
            T_TRQ:
            begin
                // Each torque component is a product pair, first minus second.
                case (idx_reg)
                    3'd0:    begin mul_a = MW'(d_reg[1]); mul_b = MW'(f_reg[2]); end
                    3'd1:    begin mul_a = MW'(d_reg[2]); mul_b = MW'(f_reg[1]); end
                    3'd2:    begin mul_a = MW'(d_reg[2]); mul_b = MW'(f_reg[0]); end
                    3'd3:    begin mul_a = MW'(d_reg[0]); mul_b = MW'(f_reg[2]); end
                    3'd4:    begin mul_a = MW'(d_reg[0]); mul_b = MW'(f_reg[1]); end
                    default: begin mul_a = MW'(d_reg[1]); mul_b = MW'(f_reg[0]); end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rbfta_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_comb
    begin
        acc_next = acc_reg + 66'(mul_prod);
        s_wide = (-acc_next + 66'sd536870912) >>> 30;
        scl_round = (mul_prod + PW'(64'sd536870912)) >>> 30;
        trq_diff = (PW+1)'(a_reg) - (PW+1)'(mul_prod) + (PW+1)'(32'sd32768);
        trq_round = trq_diff >>> 16;
        case (idx_reg)
            3'd0:    fsum_sel = fsum_reg[0];
            3'd1:    fsum_sel = fsum_reg[1];
            default: fsum_sel = fsum_reg[2];
        endcase
        case (idx_reg)
            3'd0, 3'd1: tsum_sel = tsum_reg[0];
            3'd2, 3'd3: tsum_sel = tsum_reg[1];
            default:    tsum_sel = tsum_reg[2];
        endcase
        fsum_new = rbfta_pkg::sat_add(fsum_sel, scl_round[49:0]);
        tsum_new = rbfta_pkg::sat_add(tsum_sel, trq_round[49:0]);
    end

    assign load_out = (state_reg == T_FIN) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            wait_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                fsum_reg[i] <= '0;
                tsum_reg[i] <= '0;
            end
        end
        else
        begin
            if (load_out) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;

            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            f_reg[i] <= f_in[i];
                            d_reg[i] <= d_in[i];
                        end
                        wait_reg <= 1'b0;
                        idx_reg  <= '0;
                        acc_reg  <= '0;
                        if (fzero)
                        begin
                            if (in_data.clear_sums)
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    fsum_reg[i] <= '0;
                                    tsum_reg[i] <= '0;
                                end
                            end
                            state_reg <= T_FIN;
                        end
                        else if (dzero)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                fsum_reg[i] <= rbfta_pkg::sat_add(
                                    in_data.clear_sums ? 32'sd0 : fsum_reg[i],
                                    50'(f_in[i]));
                                if (in_data.clear_sums) tsum_reg[i] <= '0;
                            end
                            state_reg <= T_FIN;
                        end
                        else
                        begin
                            if (in_data.clear_sums)
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    fsum_reg[i] <= '0;
                                    tsum_reg[i] <= '0;
                                end
                            end
                            state_reg <= T_UD;
                        end
                    end
                end
                T_UD, T_UF:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (unit_done)
                    begin
                        wait_reg <= 1'b0;
                        if (state_reg == T_UD)
                        begin
                            u_reg     <= unit_u;
                            state_reg <= T_UF;
                        end
                        else
                        begin
                            v_reg     <= unit_u;
                            idx_reg   <= '0;
                            state_reg <= T_DOT;
                        end
                    end
                end
                T_DOT:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        wait_reg <= 1'b0;
                        acc_reg  <= acc_next;
                        if (idx_reg == 3'd2)
                        begin
                            s_reg     <= s_wide[33:0];
                            idx_reg   <= '0;
                            state_reg <= T_SCL;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                T_SCL:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        wait_reg <= 1'b0;
                        case (idx_reg)
                            3'd0:    fsum_reg[0] <= fsum_new;
                            3'd1:    fsum_reg[1] <= fsum_new;
                            default: fsum_reg[2] <= fsum_new;
                        endcase
                        if (idx_reg == 3'd2)
                        begin
                            idx_reg   <= '0;
                            state_reg <= T_TRQ;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                T_TRQ:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        wait_reg <= 1'b0;
                        if (!idx_reg[0])
                        begin
                            a_reg <= mul_prod;
                        end
                        else
                        begin
                            case (idx_reg)
                                3'd1:    tsum_reg[0] <= tsum_new;
                                3'd3:    tsum_reg[1] <= tsum_new;
                                default: tsum_reg[2] <= tsum_new;
                            endcase
                        end
                        if (idx_reg == 3'd5) state_reg <= T_FIN;
                        else idx_reg <= idx_reg + 3'd1;
                    end
                end
                T_FIN:
                begin
                    if (load_out)
                    begin
                        out_reg.sum_force_x  <= fsum_reg[0];
                        out_reg.sum_force_y  <= fsum_reg[1];
                        out_reg.sum_force_z  <= fsum_reg[2];
                        out_reg.sum_torque_x <= tsum_reg[0];
                        out_reg.sum_torque_y <= tsum_reg[1];
                        out_reg.sum_torque_z <= tsum_reg[2];
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule
`default_nettype wire

// File: src/rbfta_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module rbfta_mul (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [rbfta_pkg::MUL_W-1:0]    a,
    input  wire logic signed [rbfta_pkg::MUL_W-1:0]    b,
    output logic                                       done,
    output logic signed [rbfta_pkg::PROD_W-1:0]        prod
);

    localparam int W = rbfta_pkg::MUL_W;
    localparam int PW = rbfta_pkg::PROD_W;

    logic [W-1:0]  ma_reg;
    logic [PW-1:0] p_reg;
    logic [PW-1:0] p_next;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic          fin_reg;
    logic          neg_reg;
    logic          done_reg;
    logic signed [PW-1:0] prod_reg;
    logic [W-1:0]  abs_a;
    logic [W-1:0]  abs_b;
    logic [W:0]    sum;

    assign abs_a = a[W-1] ? W'(-a) : W'(a);
    assign abs_b = b[W-1] ? W'(-b) : W'(b);

    // One multiplier bit per cycle: add the multiplicand into the high half, shift right.
    always_comb
    begin
        sum = {1'b0, p_reg[PW-1:W]} + (p_reg[0] ? {1'b0, ma_reg} : '0);
        p_next = {sum, p_reg[W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                ma_reg   <= abs_a;
                p_reg    <= {{W{1'b0}}, abs_b};
                neg_reg  <= a[W-1] ^ b[W-1];
                cnt_reg  <= 6'(W);
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
            end
            else if (busy_reg)
            begin
                p_reg   <= p_next;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                prod_reg <= neg_reg ? -$signed(p_reg) : $signed(p_reg);
                done_reg <= 1'b1;
                fin_reg  <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule
`default_nettype wire

// File: src/rbfta_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module rbfta_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [32:0] vec [3],
    output logic                    done,
    output logic signed [31:0]      u [3]
);

    typedef enum logic [2:0] {U_IDLE, U_NORM, U_SQ, U_ROOT, U_DSET, U_DIV} ustate_t;

    ustate_t     state_reg;
    logic [32:0] mag_reg [3];
    logic [32:0] m_reg;
    logic [2:0]  neg_reg;
    logic [1:0]  idx_reg;
    logic        wait_reg;
    logic [63:0] sq_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] rbit_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] len_reg;
    logic [61:0] num_reg;
    logic [31:0] rem_reg;
    logic        done_reg;
    logic signed [31:0] u_reg [3];

    logic [32:0] mag_in [3];
    logic [32:0] m_in;
    logic [32:0] mag_sel;
    logic        neg_sel;
    logic [63:0] root_t;
    logic [63:0] res_next;
    logic [32:0] rem_sh;
    logic        qbit;
    logic [61:0] num_next;
    logic [31:0] q;

    logic                                    mul_start;
    logic                                    mul_done;
    logic signed [rbfta_pkg::MUL_W-1:0]      mul_op;
    logic signed [rbfta_pkg::PROD_W-1:0]     mul_prod;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = vec[i][32] ? 33'(-vec[i]) : 33'(vec[i]);
        end
        m_in = mag_in[0];
        if (mag_in[1] > m_in) m_in = mag_in[1];
        if (mag_in[2] > m_in) m_in = mag_in[2];
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    begin mag_sel = mag_reg[0]; neg_sel = neg_reg[0]; end
            2'd1:    begin mag_sel = mag_reg[1]; neg_sel = neg_reg[1]; end
            default: begin mag_sel = mag_reg[2]; neg_sel = neg_reg[2]; end
        endcase
    end

    assign mul_start = (state_reg == U_SQ) && !wait_reg;
    assign mul_op = $signed({1'b0, mag_sel});

    rbfta_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_op),
        .b     (mul_op),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_comb
    begin
        root_t = res_reg + rbit_reg;
        res_next = (x_reg >= root_t) ? ((res_reg >> 1) + rbit_reg) : (res_reg >> 1);
        rem_sh = {rem_reg, num_reg[61]};
        qbit = rem_sh >= {1'b0, len_reg};
        num_next = {num_reg[60:0], qbit};
        q = num_next[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            wait_reg  <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            mag_reg[i] <= mag_in[i];
                            neg_reg[i] <= vec[i][32];
                        end
                        m_reg     <= m_in;
                        state_reg <= U_NORM;
                    end
                end
                U_NORM:
                begin
                    // Bring the largest magnitude into [2^30, 2^31), one shift a cycle.
                    if (m_reg[32:31] != 2'b00)
                    begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                        state_reg <= U_SQ;
                        idx_reg   <= 2'd0;
                        sq_reg    <= '0;
                        wait_reg  <= 1'b0;
                    end
                    else if (!m_reg[30])
                    begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                        m_reg <= m_reg << 1;
                    end
                    else
                    begin
                        state_reg <= U_SQ;
                        idx_reg   <= 2'd0;
                        sq_reg    <= '0;
                        wait_reg  <= 1'b0;
                    end
                end
                U_SQ:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        wait_reg <= 1'b0;
                        if (idx_reg == 2'd2)
                        begin
                            x_reg     <= sq_reg + mul_prod[63:0];
                            res_reg   <= '0;
                            rbit_reg  <= 64'd1 << 62;
                            cnt_reg   <= '0;
                            state_reg <= U_ROOT;
                        end
                        else
                        begin
                            sq_reg  <= sq_reg + mul_prod[63:0];
                            idx_reg <= idx_reg + 2'd1;
                        end
                    end
                end
                U_ROOT:
                begin
                    if (x_reg >= root_t) x_reg <= x_reg - root_t;
                    res_reg  <= res_next;
                    rbit_reg <= rbit_reg >> 2;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                    begin
                        len_reg   <= res_next[31:0];
                        idx_reg   <= 2'd0;
                        state_reg <= U_DSET;
                    end
                end
                U_DSET:
                begin
                    num_reg   <= {1'b0, mag_sel[30:0], 30'd0} + 62'(len_reg >> 1);
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= U_DIV;
                end
                U_DIV:
                begin
                    // Restoring division, one quotient bit a cycle.
                    if (qbit) rem_reg <= 32'(rem_sh - {1'b0, len_reg});
                    else rem_reg <= rem_sh[31:0];
                    num_reg <= num_next;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd61)
                    begin
                        u_reg[idx_reg] <= neg_sel ? -$signed(q) : $signed(q);
                        if (idx_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= U_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= U_DSET;
                        end
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign u = u_reg;

endmodule
`default_nettype wire
